### rtl/phfe_pkg.sv
// Package for the packet header field extractor: beat type, link codes,
// ethertypes and register map. No dependencies.
`default_nettype none

package phfe_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [1:0] LINK_ETH  = 2'd0;
  localparam logic [1:0] LINK_SLL  = 2'd1;
  localparam logic [1:0] LINK_RAW  = 2'd2;
  localparam logic [1:0] LINK_LOOP = 2'd3;

  localparam logic [15:0] ET_VLAN = 16'h8100;
  localparam logic [15:0] ET_ARP  = 16'h0806;
  localparam logic [15:0] ET_IP4  = 16'h0800;
  localparam logic [15:0] ET_IP6  = 16'h86DD;

  localparam logic [31:0] AF_INET   = 32'd2;
  localparam logic [31:0] AF_INET6A = 32'd24;
  localparam logic [31:0] AF_INET6B = 32'd28;
  localparam logic [31:0] AF_INET6C = 32'd30;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [0:0] REG_LINK_TYPE = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       cnt_en;
    logic [1:0] link_type;
  } phfe_beat_t;

endpackage

`default_nettype wire

### rtl/phfe_front.sv
// Front end: byte offset counter and the beat queue feeding the parser.
// Depends on phfe_pkg.
`default_nettype none

module phfe_front #(
  parameter int COUNT_BITS = phfe_pkg::COUNT_BITS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [7:0]              in_data_byte,
  input  wire                     in_last_byte,
  input  wire  [1:0]              link_type,
  output logic                    q_valid,
  output phfe_pkg::phfe_beat_t    q_beat,
  output logic [COUNT_BITS-1:0]   q_off,
  input  wire                     q_pop
);

  localparam int PW = $clog2(phfe_pkg::QUEUE_DEPTH);
  localparam int CNTW = $clog2(phfe_pkg::QUEUE_DEPTH + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  phfe_pkg::phfe_beat_t          beat_mem [phfe_pkg::QUEUE_DEPTH];
  logic [COUNT_BITS-1:0]         off_mem  [phfe_pkg::QUEUE_DEPTH];
  logic [PW-1:0]                 wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]               fill_r, fill_nxt;
  logic [COUNT_BITS-1:0]         off_r, off_nxt;
  logic                          push;
  logic                          cnt_en;
  phfe_pkg::phfe_beat_t          wr_beat;

  assign in_ready = (fill_r != CNTW'(phfe_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign cnt_en   = (off_r != COUNT_MAX);
  assign q_valid  = (fill_r != '0);
  assign q_beat   = beat_mem[rd_ptr_r];
  assign q_off    = off_mem[rd_ptr_r];

  always_comb begin
    wr_beat.data_byte = in_data_byte;
    wr_beat.last_byte = in_last_byte;
    wr_beat.cnt_en    = cnt_en;
    wr_beat.link_type = link_type;
    off_nxt    = off_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + PW'(1);
      if (in_last_byte) begin
        off_nxt = '0;
      end else if (cnt_en) begin
        off_nxt = off_r + COUNT_BITS'(1);
      end
    end
    if (q_pop) begin
      rd_ptr_nxt = rd_ptr_r + PW'(1);
    end
    if (push && !q_pop) begin
      fill_nxt = fill_r + CNTW'(1);
    end else if (!push && q_pop) begin
      fill_nxt = fill_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      off_r    <= off_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      beat_mem[wr_ptr_r] <= wr_beat;
      off_mem[wr_ptr_r]  <= off_r;
    end
  end

endmodule

`default_nettype wire

### rtl/phfe_back.sv
// Back end: per-byte header parser and the registered result stage.
// Depends on phfe_pkg; fed by phfe_front.
`default_nettype none

module phfe_back #(
  parameter int COUNT_BITS = phfe_pkg::COUNT_BITS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     q_valid,
  input  phfe_pkg::phfe_beat_t    q_beat,
  input  wire  [COUNT_BITS-1:0]   q_off,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic                    out_is_arp,
  output logic                    out_has_ip,
  output logic [2:0]              out_ip_version,
  output logic [7:0]              out_ip_proto,
  output logic [63:0]             out_src_addr_high,
  output logic [63:0]             out_src_addr_low,
  output logic [63:0]             out_dst_addr_high,
  output logic [63:0]             out_dst_addr_low,
  output logic                    out_has_transport,
  output logic [15:0]             out_src_port,
  output logic [15:0]             out_dst_port
);

  localparam int CW = COUNT_BITS;
  localparam logic [1:0] PH_LINK = 2'd0;
  localparam logic [1:0] PH_VLAN = 2'd1;
  localparam logic [1:0] PH_IP   = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  function automatic logic [1:0] kind_phase(input logic [15:0] kind);
    logic [1:0] ph;
    if (kind == phfe_pkg::ET_VLAN) begin
      ph = PH_VLAN;
    end else if (kind == phfe_pkg::ET_IP4 || kind == phfe_pkg::ET_IP6) begin
      ph = PH_IP;
    end else begin
      ph = PH_DONE;
    end
    return ph;
  endfunction

  function automatic logic [5:0] ihl_len(input logic [7:0] b);
    logic [5:0] h;
    h = {b[3:0], 2'b00};
    if (h < 6'd20) begin
      h = 6'd20;
    end
    return h;
  endfunction

  logic [1:0]    phase_r, phase_nxt;
  logic [15:0]   kind_r, kind_nxt;
  logic [CW-1:0] ip_start_r, ip_start_nxt;
  logic [5:0]    hlen_r, hlen_nxt;
  logic [31:0]   fam_r, fam_nxt;
  logic [7:0]    proto_r, proto_nxt;
  logic [63:0]   src_hi_r, src_hi_nxt, src_lo_r, src_lo_nxt;
  logic [63:0]   dst_hi_r, dst_hi_nxt, dst_lo_r, dst_lo_nxt;
  logic [15:0]   sport_r, sport_nxt, dport_r, dport_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          arp_r, hip_r, tr_r;
  logic [2:0]    ver_r;
  logic [7:0]    oproto_r;
  logic [63:0]   osh_r, osl_r, odh_r, odl_r;
  logic [15:0]   osp_r, odp_r;

  logic          fire, load;
  logic [7:0]    b;
  logic [CW-1:0] rel, hi_off, port_d, len, avail;
  logic [15:0]   kword;
  logic [3:0]    ver_nib;
  logic [6:0]    need;
  logic          ok4, ok6;
  logic          res_arp, res_hip, res_tr;
  logic [2:0]    res_ver;
  logic [7:0]    res_proto;
  logic [63:0]   res_sh, res_sl, res_dh, res_dl;
  logic [15:0]   res_sp, res_dp;

  assign fire  = q_valid && (!q_beat.last_byte || !out_valid_r || out_ready);
  assign q_pop = fire;
  assign load  = fire && q_beat.last_byte;
  assign b     = q_beat.data_byte;

  always_comb begin
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    ip_start_nxt = ip_start_r;
    hlen_nxt     = hlen_r;
    fam_nxt      = fam_r;
    proto_nxt    = proto_r;
    src_hi_nxt   = src_hi_r;
    src_lo_nxt   = src_lo_r;
    dst_hi_nxt   = dst_hi_r;
    dst_lo_nxt   = dst_lo_r;
    sport_nxt    = sport_r;
    dport_nxt    = dport_r;
    rel          = q_off - ip_start_r;
    port_d       = rel - CW'(hlen_r);
    hi_off       = (q_beat.link_type == phfe_pkg::LINK_ETH) ? CW'(12) : CW'(14);
    kword        = {kind_r[15:8], b};
    ver_nib      = b[7:4];
    if (fire && q_beat.cnt_en) begin
      case (phase_r)
        PH_LINK: begin
          case (q_beat.link_type)
            phfe_pkg::LINK_ETH, phfe_pkg::LINK_SLL: begin
              if (q_off == hi_off) begin
                kind_nxt = {b, 8'h00};
              end else if (q_off == hi_off + CW'(1)) begin
                kind_nxt = kword;
                if (q_beat.link_type == phfe_pkg::LINK_SLL && kword == phfe_pkg::ET_VLAN) begin
                  phase_nxt = PH_DONE;
                end else begin
                  ip_start_nxt = hi_off + CW'(2);
                  phase_nxt    = kind_phase(kword);
                end
              end
            end
            phfe_pkg::LINK_RAW: begin
              if (q_off == '0) begin
                if (ver_nib == 4'd4) begin
                  kind_nxt     = phfe_pkg::ET_IP4;
                  phase_nxt    = PH_IP;
                  ip_start_nxt = '0;
                  hlen_nxt     = ihl_len(b);
                end else if (ver_nib == 4'd6) begin
                  kind_nxt     = phfe_pkg::ET_IP6;
                  phase_nxt    = PH_IP;
                  ip_start_nxt = '0;
                end else begin
                  phase_nxt = PH_DONE;
                end
              end
            end
            default: begin
              if (q_off < CW'(4)) begin
                fam_nxt = fam_r | (32'(b) << {q_off[1:0], 3'b000});
                if (q_off == CW'(3)) begin
                  if (fam_nxt == phfe_pkg::AF_INET) begin
                    kind_nxt = phfe_pkg::ET_IP4;
                  end else if (fam_nxt == phfe_pkg::AF_INET6A ||
                               fam_nxt == phfe_pkg::AF_INET6B ||
                               fam_nxt == phfe_pkg::AF_INET6C) begin
                    kind_nxt = phfe_pkg::ET_IP6;
                  end else begin
                    kind_nxt = '0;
                  end
                  ip_start_nxt = CW'(4);
                  phase_nxt    = kind_phase(kind_nxt);
                end
              end
            end
          endcase
        end
        PH_VLAN: begin
          if (q_off >= ip_start_r) begin
            if (rel == CW'(2)) begin
              kind_nxt = {b, 8'h00};
            end else if (rel == CW'(3)) begin
              kind_nxt     = kword;
              ip_start_nxt = ip_start_r + CW'(4);
              phase_nxt    = kind_phase(kword);
            end
          end
        end
        PH_IP: begin
          if (q_off >= ip_start_r) begin
            if (kind_r == phfe_pkg::ET_IP4) begin
              if (rel == '0) begin
                hlen_nxt = ihl_len(b);
              end else if (rel == CW'(9)) begin
                proto_nxt = b;
              end else if (rel >= CW'(12) && rel < CW'(16)) begin
                src_lo_nxt = {src_lo_r[55:0], b};
              end else if (rel >= CW'(16) && rel < CW'(20)) begin
                dst_lo_nxt = {dst_lo_r[55:0], b};
              end else if (rel >= CW'(hlen_r) && port_d < CW'(4)) begin
                if (port_d[1]) begin
                  dport_nxt = {dport_r[7:0], b};
                end else begin
                  sport_nxt = {sport_r[7:0], b};
                end
              end
            end else if (kind_r == phfe_pkg::ET_IP6) begin
              if (rel == CW'(6)) begin
                proto_nxt = b;
              end else if (rel >= CW'(8) && rel < CW'(16)) begin
                src_hi_nxt = {src_hi_r[55:0], b};
              end else if (rel >= CW'(16) && rel < CW'(24)) begin
                src_lo_nxt = {src_lo_r[55:0], b};
              end else if (rel >= CW'(24) && rel < CW'(32)) begin
                dst_hi_nxt = {dst_hi_r[55:0], b};
              end else if (rel >= CW'(32) && rel < CW'(40)) begin
                dst_lo_nxt = {dst_lo_r[55:0], b};
              end else if (rel >= CW'(40) && rel < CW'(42)) begin
                sport_nxt = {sport_r[7:0], b};
              end else if (rel >= CW'(42) && rel < CW'(44)) begin
                dport_nxt = {dport_r[7:0], b};
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    len       = q_beat.cnt_en ? q_off + CW'(1) : q_off;
    avail     = len - ip_start_nxt;
    ok4       = (kind_nxt == phfe_pkg::ET_IP4) && (avail >= CW'(20));
    ok6       = (kind_nxt == phfe_pkg::ET_IP6) && (avail >= CW'(40));
    need      = ok4 ? ({1'b0, hlen_nxt} + 7'd4) : 7'd44;
    res_arp   = 1'b0;
    res_hip   = 1'b0;
    res_ver   = 3'd0;
    res_proto = 8'd0;
    res_sh    = '0;
    res_sl    = '0;
    res_dh    = '0;
    res_dl    = '0;
    res_tr    = 1'b0;
    res_sp    = '0;
    res_dp    = '0;
    if (phase_nxt == PH_DONE) begin
      res_arp = (kind_nxt == phfe_pkg::ET_ARP);
    end else if (phase_nxt == PH_IP && len >= ip_start_nxt && (ok4 || ok6)) begin
      res_hip   = 1'b1;
      res_ver   = ok4 ? 3'd4 : 3'd6;
      res_proto = proto_nxt;
      if (ok4) begin
        res_sl = {32'd0, src_lo_nxt[31:0]};
        res_dl = {32'd0, dst_lo_nxt[31:0]};
      end else begin
        res_sh = src_hi_nxt;
        res_sl = src_lo_nxt;
        res_dh = dst_hi_nxt;
        res_dl = dst_lo_nxt;
      end
      if (avail >= CW'(need) &&
          (proto_nxt == phfe_pkg::PROTO_TCP || proto_nxt == phfe_pkg::PROTO_UDP)) begin
        res_tr = 1'b1;
        res_sp = sport_nxt;
        res_dp = dport_nxt;
      end
    end

    if (load) begin
      phase_nxt    = PH_LINK;
      kind_nxt     = '0;
      ip_start_nxt = '0;
      hlen_nxt     = 6'd20;
      fam_nxt      = '0;
      proto_nxt    = '0;
      src_hi_nxt   = '0;
      src_lo_nxt   = '0;
      dst_hi_nxt   = '0;
      dst_lo_nxt   = '0;
      sport_nxt    = '0;
      dport_nxt    = '0;
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LINK;
      kind_r      <= '0;
      ip_start_r  <= '0;
      hlen_r      <= 6'd20;
      fam_r       <= '0;
      proto_r     <= '0;
      src_hi_r    <= '0;
      src_lo_r    <= '0;
      dst_hi_r    <= '0;
      dst_lo_r    <= '0;
      sport_r     <= '0;
      dport_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      ip_start_r  <= ip_start_nxt;
      hlen_r      <= hlen_nxt;
      fam_r       <= fam_nxt;
      proto_r     <= proto_nxt;
      src_hi_r    <= src_hi_nxt;
      src_lo_r    <= src_lo_nxt;
      dst_hi_r    <= dst_hi_nxt;
      dst_lo_r    <= dst_lo_nxt;
      sport_r     <= sport_nxt;
      dport_r     <= dport_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      arp_r    <= res_arp;
      hip_r    <= res_hip;
      ver_r    <= res_ver;
      oproto_r <= res_proto;
      osh_r    <= res_sh;
      osl_r    <= res_sl;
      odh_r    <= res_dh;
      odl_r    <= res_dl;
      tr_r     <= res_tr;
      osp_r    <= res_sp;
      odp_r    <= res_dp;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_arp        = arp_r;
  assign out_has_ip        = hip_r;
  assign out_ip_version    = ver_r;
  assign out_ip_proto      = oproto_r;
  assign out_src_addr_high = osh_r;
  assign out_src_addr_low  = osl_r;
  assign out_dst_addr_high = odh_r;
  assign out_dst_addr_low  = odl_r;
  assign out_has_transport = tr_r;
  assign out_src_port      = osp_r;
  assign out_dst_port      = odp_r;

endmodule

`default_nettype wire

### rtl/packet_header_field_extractor.sv
// Top level of the packet header field extractor: config register, front end
// and back end. Depends on phfe_pkg, phfe_front and phfe_back.
`default_nettype none

// Takes one packet byte per cycle while in_ready is high and returns one result
// beat per packet, after the byte marked last. Bytes pass through a four-entry
// queue into the parser, which consumes one byte per cycle unless a last byte
// waits on a held result, so the sustained rate is one byte per clock while
// out_ready keeps up; each last byte is queued, then its result is registered.
// The queue fills only while a finished result waits on out_ready. The link
// type register sits at byte address 0 and should be written between packets.
module packet_header_field_extractor #(
  parameter int COUNT_BITS = phfe_pkg::COUNT_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_last_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_is_arp,
  output logic        out_has_ip,
  output logic [2:0]  out_ip_version,
  output logic [7:0]  out_ip_proto,
  output logic [63:0] out_src_addr_high,
  output logic [63:0] out_src_addr_low,
  output logic [63:0] out_dst_addr_high,
  output logic [63:0] out_dst_addr_low,
  output logic        out_has_transport,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [1:0]             link_r, link_nxt;
  logic                   cfg_wr;
  logic                   q_valid, q_pop;
  phfe_pkg::phfe_beat_t   q_beat;
  logic [COUNT_BITS-1:0]  q_off;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2:2] == phfe_pkg::REG_LINK_TYPE);
  assign link_nxt   = cfg_wr ? cfg_pwdata[1:0] : link_r;
  assign cfg_prdata = (cfg_paddr[2:2] == phfe_pkg::REG_LINK_TYPE) ? {30'd0, link_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= phfe_pkg::LINK_ETH;
    end else begin
      link_r <= link_nxt;
    end
  end

  phfe_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .link_type    (link_r),
    .q_valid      (q_valid),
    .q_beat       (q_beat),
    .q_off        (q_off),
    .q_pop        (q_pop)
  );

  phfe_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_beat            (q_beat),
    .q_off             (q_off),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_arp        (out_is_arp),
    .out_has_ip        (out_has_ip),
    .out_ip_version    (out_ip_version),
    .out_ip_proto      (out_ip_proto),
    .out_src_addr_high (out_src_addr_high),
    .out_src_addr_low  (out_src_addr_low),
    .out_dst_addr_high (out_dst_addr_high),
    .out_dst_addr_low  (out_dst_addr_low),
    .out_has_transport (out_has_transport),
    .out_src_port      (out_src_port),
    .out_dst_port      (out_dst_port)
  );

endmodule

`default_nettype wire

### rtl/phfe_checker.sv
// Port-level checker for the packet header field extractor and its bind.
// Depends on packet_header_field_extractor.
`default_nettype none

module phfe_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire [7:0]  in_data_byte,
  input wire        in_last_byte,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_is_arp,
  input wire        out_has_ip,
  input wire [2:0]  out_ip_version,
  input wire [7:0]  out_ip_proto,
  input wire [63:0] out_src_addr_high,
  input wire [63:0] out_src_addr_low,
  input wire [63:0] out_dst_addr_high,
  input wire [63:0] out_dst_addr_low,
  input wire        out_has_transport,
  input wire [15:0] out_src_port,
  input wire [15:0] out_dst_port,
  input wire        cfg_psel,
  input wire        cfg_penable,
  input wire        cfg_pwrite,
  input wire [2:0]  cfg_paddr,
  input wire [31:0] cfg_pwdata,
  input wire [31:0] cfg_prdata,
  input wire        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_src_addr_low) &&
      $stable(out_dst_addr_low) && $stable(out_src_port) && $stable(out_dst_port))
    else $error("result beat changed while stalled");

  a_no_ip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_ip |-> out_ip_version == 3'd0 && out_ip_proto == 8'd0 &&
      !out_has_transport && out_src_addr_low == 64'd0 && out_dst_addr_low == 64'd0)
    else $error("fields set without an IP header");

  a_ip_version: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_ip |-> !out_is_arp &&
      (out_ip_version == 3'd4 || out_ip_version == 3'd6))
    else $error("bad IP version or ARP with IP");

  a_ipv4_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ip_version == 3'd4 |-> out_src_addr_high == 64'd0 &&
      out_dst_addr_high == 64'd0 && out_src_addr_low[63:32] == 32'd0 &&
      out_dst_addr_low[63:32] == 32'd0)
    else $error("IPv4 address exceeds 32 bits");

  a_ports_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_transport |-> out_src_port == 16'd0 && out_dst_port == 16'd0)
    else $error("ports set without transport");

endmodule

bind packet_header_field_extractor phfe_checker u_phfe_checker (.*);

`default_nettype wire
